>>> rtl/tcp_option_parser_defines.svh
// assertion macros for the tcp option parser
// expects aclk and aresetn in the scope of each use
`ifndef TCP_OPTION_PARSER_DEFINES_SVH
`define TCP_OPTION_PARSER_DEFINES_SVH

// same-cycle implication, quiet during reset
`define TOPT_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define TOPT_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/topt_pkg.sv
// shared types and constants for the tcp option parser
// no dependencies
package topt_pkg;

    localparam int MAX_OPTION_BYTES_DEF = 40;

    localparam int POS_W = 6;   // byte position, saturates at all ones
    localparam int END_W = 7;   // option start/end positions, saturate at all ones

    // option kinds
    localparam logic [7:0] KIND_EOL    = 8'd0;
    localparam logic [7:0] KIND_NOP    = 8'd1;
    localparam logic [7:0] KIND_MSS    = 8'd2;
    localparam logic [7:0] KIND_WSCALE = 8'd3;
    localparam logic [7:0] KIND_TSTAMP = 8'd8;

    // required option lengths
    localparam logic [7:0] LEN_MIN    = 8'd2;
    localparam logic [7:0] LEN_MSS    = 8'd4;
    localparam logic [7:0] LEN_WSCALE = 8'd3;
    localparam logic [7:0] LEN_TSTAMP = 8'd10;

    localparam logic [7:0] SCALE_MAX  = 8'd14;
    localparam logic [END_W-1:0] ECHO_BYTES = 7'd4;

    // found flag bits
    localparam int FLAG_MSS    = 0;
    localparam int FLAG_WSCALE = 1;
    localparam int FLAG_TSTAMP = 2;

    typedef struct packed {
        logic [7:0] opt_byte;
        logic       last_byte;
    } topt_in_t;

    typedef struct packed {
        logic        mss_found;
        logic [15:0] mss_value;
        logic        scale_found;
        logic [14:0] scale_factor;
        logic        stamp_found;
        logic [31:0] stamp_value;
    } topt_out_t;

endpackage

>>> rtl/topt_walker.sv
// option list walker: per-byte state update and result formatting
// depends on topt_pkg
module topt_walker #(
    parameter int MAX_OPTION_BYTES = topt_pkg::MAX_OPTION_BYTES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  topt_pkg::topt_in_t  item,
    output topt_pkg::topt_out_t result
);
    import topt_pkg::*;

    typedef enum logic [1:0] {
        PH_KIND,
        PH_LEN,
        PH_BODY
    } phase_t;

    logic [POS_W-1:0] byte_count_reg, byte_count_next;
    logic [END_W-1:0] next_start_reg, next_start_next;
    phase_t           phase_reg, phase_next;
    logic [7:0]       kind_reg, kind_next;
    logic             stopped_reg, stopped_next;
    logic [2:0]       found_reg, found_next;
    logic [END_W-1:0] pend_end_reg, pend_end_next;
    logic [15:0]      mss_reg, mss_next;
    logic [3:0]       scale_reg, scale_next;
    logic [31:0]      stamp_reg, stamp_next;

    // state after walking the current byte, before the end-of-segment clear
    logic [END_W-1:0] w_next_start;
    phase_t           w_phase;
    logic [7:0]       w_kind;
    logic             w_stopped;
    logic [2:0]       w_found;
    logic [END_W-1:0] w_pend_end;
    logic [15:0]      w_mss;
    logic [3:0]       w_scale;
    logic [31:0]      w_stamp;

    logic [END_W-1:0] pos;
    logic [END_W-1:0] pos_plus1;
    logic [8:0]       opt_end;
    logic [END_W-1:0] opt_end_sat;
    logic [END_W-1:0] remain;
    logic             capture;
    logic [7:0]       b;

    always_comb begin
        b           = item.opt_byte;
        pos         = {1'b0, byte_count_reg};
        pos_plus1   = pos + 7'd1;
        opt_end     = 9'(byte_count_reg) + 9'(b) - 9'd1;
        opt_end_sat = (opt_end > 9'd127) ? 7'd127 : opt_end[END_W-1:0];
        remain      = pend_end_reg - pos;
        capture     = (pend_end_reg != '0) && (pos < pend_end_reg);

        w_next_start = next_start_reg;
        w_phase      = phase_reg;
        w_kind       = kind_reg;
        w_stopped    = stopped_reg;
        w_found      = found_reg;
        w_pend_end   = pend_end_reg;
        w_mss        = mss_reg;
        w_scale      = scale_reg;
        w_stamp      = stamp_reg;

        if (byte_count_reg < POS_W'(MAX_OPTION_BYTES) && !stopped_reg) begin
            case (phase_reg)
                PH_KIND: begin
                    if (b == KIND_EOL) begin
                        w_stopped = 1'b1;
                    end else if (b == KIND_NOP) begin
                        w_next_start = pos_plus1;
                    end else begin
                        w_kind  = b;
                        w_phase = PH_LEN;
                    end
                end
                PH_LEN: begin
                    if (b < LEN_MIN) begin
                        w_stopped = 1'b1;
                    end else begin
                        w_next_start = opt_end_sat;
                        w_pend_end   = '0;
                        if ((kind_reg == KIND_MSS && b == LEN_MSS && !found_reg[FLAG_MSS]) ||
                            (kind_reg == KIND_WSCALE && b == LEN_WSCALE &&
                             !found_reg[FLAG_WSCALE]) ||
                            (kind_reg == KIND_TSTAMP && b == LEN_TSTAMP &&
                             !found_reg[FLAG_TSTAMP])) begin
                            w_pend_end = opt_end[END_W-1:0];
                        end
                        w_phase = (pos_plus1 >= opt_end_sat) ? PH_KIND : PH_BODY;
                    end
                end
                PH_BODY: begin
                    if (capture) begin
                        if (kind_reg == KIND_MSS) begin
                            w_mss = {mss_reg[7:0], b};
                            if (remain == 7'd1) w_found[FLAG_MSS] = 1'b1;
                        end else if (kind_reg == KIND_WSCALE) begin
                            w_scale = (b > SCALE_MAX) ? SCALE_MAX[3:0] : b[3:0];
                            if (remain == 7'd1) w_found[FLAG_WSCALE] = 1'b1;
                        end else begin
                            // timestamp value only, echo bytes dropped
                            if (remain > ECHO_BYTES) w_stamp = {stamp_reg[23:0], b};
                            if (remain == 7'd1) w_found[FLAG_TSTAMP] = 1'b1;
                        end
                        if (remain == 7'd1) w_pend_end = '0;
                    end
                    if (pos_plus1 >= next_start_reg) w_phase = PH_KIND;
                end
                default: begin
                    w_phase = PH_KIND;
                end
            endcase
        end

        result.mss_found    = w_found[FLAG_MSS];
        result.mss_value    = w_found[FLAG_MSS] ? w_mss : 16'd0;
        result.scale_found  = w_found[FLAG_WSCALE];
        result.scale_factor = w_found[FLAG_WSCALE] ? (15'd1 << w_scale) : 15'd1;
        result.stamp_found  = w_found[FLAG_TSTAMP];
        result.stamp_value  = w_found[FLAG_TSTAMP] ? w_stamp : 32'd0;

        byte_count_next = byte_count_reg;
        next_start_next = next_start_reg;
        phase_next      = phase_reg;
        kind_next       = kind_reg;
        stopped_next    = stopped_reg;
        found_next      = found_reg;
        pend_end_next   = pend_end_reg;
        mss_next        = mss_reg;
        scale_next      = scale_reg;
        stamp_next      = stamp_reg;

        if (step) begin
            if (item.last_byte) begin
                byte_count_next = '0;
                next_start_next = '0;
                phase_next      = PH_KIND;
                kind_next       = '0;
                stopped_next    = 1'b0;
                found_next      = '0;
                pend_end_next   = '0;
                mss_next        = '0;
                scale_next      = '0;
                stamp_next      = '0;
            end else begin
                byte_count_next = (byte_count_reg == '1) ? byte_count_reg
                                                         : byte_count_reg + 6'd1;
                next_start_next = w_next_start;
                phase_next      = w_phase;
                kind_next       = w_kind;
                stopped_next    = w_stopped;
                found_next      = w_found;
                pend_end_next   = w_pend_end;
                mss_next        = w_mss;
                scale_next      = w_scale;
                stamp_next      = w_stamp;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
            next_start_reg <= '0;
            phase_reg      <= PH_KIND;
            kind_reg       <= '0;
            stopped_reg    <= 1'b0;
            found_reg      <= '0;
            pend_end_reg   <= '0;
            mss_reg        <= '0;
            scale_reg      <= '0;
            stamp_reg      <= '0;
        end else begin
            byte_count_reg <= byte_count_next;
            next_start_reg <= next_start_next;
            phase_reg      <= phase_next;
            kind_reg       <= kind_next;
            stopped_reg    <= stopped_next;
            found_reg      <= found_next;
            pend_end_reg   <= pend_end_next;
            mss_reg        <= mss_next;
            scale_reg      <= scale_next;
            stamp_reg      <= stamp_next;
        end
    end

endmodule

>>> rtl/tcp_option_parser.sv
// a byte transfer lands in the input register and is walked from there; a last byte's segment
// result is loaded into the result register when that byte is walked
// throughput: one option byte per cycle through the combinational walker state update; a last
// byte waits only while the result register is full and the result side is stalled
// reset: synchronous active-low aresetn clears both pipeline valids and the walker state
// the walker also clears itself after each last byte, ready for the next segment
// top level: input register, option walker, result register with valid/ready channels
// depends on topt_pkg, topt_walker and tcp_option_parser_defines.svh
module tcp_option_parser #(
    parameter int MAX_OPTION_BYTES = topt_pkg::MAX_OPTION_BYTES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  topt_pkg::topt_in_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output topt_pkg::topt_out_t m_item
);
    import topt_pkg::*;

    `include "tcp_option_parser_defines.svh"

    // input stage
    logic       in_valid_reg;
    topt_in_t   in_item_reg;

    // result stage
    logic       out_valid_reg;
    topt_out_t  out_item_reg;

    // walker handshake
    logic       step;
    logic       step_last;
    topt_out_t  walk_result;

    // a held byte is walked now unless it closes a segment whose result
    // cannot land because the result register is full and not draining
    assign step      = in_valid_reg &&
                       (!in_item_reg.last_byte || !out_valid_reg || m_ready);
    assign step_last = step && in_item_reg.last_byte;

    // input register frees up whenever its byte is walked
    assign s_ready = !in_valid_reg || step;

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    topt_walker #(
        .MAX_OPTION_BYTES(MAX_OPTION_BYTES)
    ) u_walker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (in_item_reg),
        .result  (walk_result)
    );

    // control flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (step_last) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= s_item;
        end
        if (step_last) begin
            out_item_reg <= walk_result;
        end
    end

    // a segment end stuck behind a full, stalled result must block new transfers
    `TOPT_ASSERT_NOW(a_last_blocks, in_valid_reg && in_item_reg.last_byte && out_valid_reg && !m_ready, !s_ready, "last byte walked over a stalled result")
    // a walked last byte always produces a result next cycle
    `TOPT_ASSERT_NEXT(a_last_gives_result, step_last, out_valid_reg, "segment end produced no result")
    // window multiplier is always a single power of two
    `TOPT_ASSERT_NOW(a_scale_onehot, out_valid_reg, $onehot(out_item_reg.scale_factor), "scale factor not a power of two")
    // absent mss and timestamp options report zero values
    `TOPT_ASSERT_NOW(a_absent_zero, out_valid_reg && (!out_item_reg.mss_found || !out_item_reg.stamp_found), (out_item_reg.mss_found || out_item_reg.mss_value == 16'd0) && (out_item_reg.stamp_found || out_item_reg.stamp_value == 32'd0), "missing option with nonzero value")

endmodule

>>> test/topt_checker.sv
// result checker for tcp_option_parser: watches both channels, predicts the segment summary
// from the accepted option bytes and compares every result transfer against it
// depends on topt_pkg
module topt_checker
    import topt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  topt_in_t  s_item,
    input  logic      m_valid,
    input  logic      m_ready,
    input  topt_out_t m_item,
    output int        fail_count,
    output int        outstanding,
    output int        checked_count
);

    typedef enum logic [2:0] {WALK_KIND, WALK_LEN, WALK_BODY} walk_phase_t;

    // shadow copy of the option walk
    logic [POS_W-1:0] pos_cnt;
    logic [END_W-1:0] next_start;
    walk_phase_t      phase;
    logic [7:0]       cur_kind;
    logic             walk_stopped;
    logic [2:0]       found;
    logic [END_W-1:0] capture_end;
    logic [15:0]      mss_acc;
    logic [3:0]       scale_acc;
    logic [31:0]      stamp_acc;

    topt_out_t summaries_due[$];

    task automatic clear_walk();
        pos_cnt      = '0;
        next_start   = '0;
        phase        = WALK_KIND;
        cur_kind     = '0;
        walk_stopped = 1'b0;
        found        = '0;
        capture_end  = '0;
        mss_acc      = '0;
        scale_acc    = '0;
        stamp_acc    = '0;
    endtask

    task automatic walk_option_byte(input int unsigned p, input logic [7:0] b);
        int unsigned opt_end;
        int unsigned remain;
        if (walk_stopped) return;
        case (phase)
            WALK_KIND: begin
                if (b == KIND_EOL) begin
                    walk_stopped = 1'b1;
                end else if (b == KIND_NOP) begin
                    next_start = END_W'(p + 1);
                end else begin
                    cur_kind = b;
                    phase    = WALK_LEN;
                end
            end
            WALK_LEN: begin
                if (b < LEN_MIN) begin
                    walk_stopped = 1'b1;
                    return;
                end
                opt_end     = p - 1 + b;
                next_start  = (opt_end > 127) ? 7'd127 : END_W'(opt_end);
                capture_end = '0;
                if ((cur_kind == KIND_MSS && b == LEN_MSS && !found[FLAG_MSS]) ||
                    (cur_kind == KIND_WSCALE && b == LEN_WSCALE && !found[FLAG_WSCALE]) ||
                    (cur_kind == KIND_TSTAMP && b == LEN_TSTAMP && !found[FLAG_TSTAMP]))
                    capture_end = END_W'(opt_end);
                phase = (p + 1 >= next_start) ? WALK_KIND : WALK_BODY;
            end
            default: begin
                if (capture_end != 0 && p < capture_end) begin
                    remain = capture_end - p;
                    case (cur_kind)
                        KIND_MSS: begin
                            mss_acc = {mss_acc[7:0], b};
                            if (remain == 1) found[FLAG_MSS] = 1'b1;
                        end
                        KIND_WSCALE: begin
                            scale_acc = (b > SCALE_MAX) ? 4'(SCALE_MAX) : b[3:0];
                            if (remain == 1) found[FLAG_WSCALE] = 1'b1;
                        end
                        default: begin
                            // echo bytes are walked but dropped
                            if (remain > ECHO_BYTES) stamp_acc = {stamp_acc[23:0], b};
                            if (remain == 1) found[FLAG_TSTAMP] = 1'b1;
                        end
                    endcase
                    if (remain == 1) capture_end = '0;
                end
                if (p + 1 >= next_start) phase = WALK_KIND;
            end
        endcase
    endtask

    task automatic parse_option_byte(input topt_in_t it);
        topt_out_t summary;
        if (pos_cnt < MAX_OPTION_BYTES_DEF) walk_option_byte(pos_cnt, it.opt_byte);
        if (pos_cnt != '1) pos_cnt = pos_cnt + 1'b1;
        if (it.last_byte) begin
            summary.mss_found    = found[FLAG_MSS];
            summary.mss_value    = found[FLAG_MSS] ? mss_acc : 16'd0;
            summary.scale_found  = found[FLAG_WSCALE];
            summary.scale_factor = found[FLAG_WSCALE] ? (15'd1 << scale_acc) : 15'd1;
            summary.stamp_found  = found[FLAG_TSTAMP];
            summary.stamp_value  = found[FLAG_TSTAMP] ? stamp_acc : 32'd0;
            summaries_due.push_back(summary);
            clear_walk();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch in result %0d: %s got 0x%0h want 0x%0h",
                 checked_count, what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        topt_out_t want;
        if (!aresetn) begin
            clear_walk();
            summaries_due.delete();
        end else begin
            // results leave before the same edge's byte can add a new expectation
            if (m_valid && m_ready) begin
                if (summaries_due.size() == 0) begin
                    $display("result transfer with no segment outstanding");
                    fail_count++;
                end else begin
                    want = summaries_due.pop_front();
                    if (m_item.mss_found !== want.mss_found)
                        report_mismatch("mss_found", m_item.mss_found, want.mss_found);
                    if (m_item.mss_value !== want.mss_value)
                        report_mismatch("mss_value", m_item.mss_value, want.mss_value);
                    if (m_item.scale_found !== want.scale_found)
                        report_mismatch("scale_found", m_item.scale_found, want.scale_found);
                    if (m_item.scale_factor !== want.scale_factor)
                        report_mismatch("scale_factor", m_item.scale_factor,
                                        want.scale_factor);
                    if (m_item.stamp_found !== want.stamp_found)
                        report_mismatch("stamp_found", m_item.stamp_found, want.stamp_found);
                    if (m_item.stamp_value !== want.stamp_value)
                        report_mismatch("stamp_value", m_item.stamp_value, want.stamp_value);
                end
                checked_count++;
            end
            if (s_valid && s_ready) parse_option_byte(s_item);
        end
        outstanding = summaries_due.size();
    end

endmodule

>>> test/tb_top.sv
// top of the tcp_option_parser testbench: clock, reset, option byte stimulus and verdict
// depends on topt_pkg, the tcp_option_parser rtl and topt_checker
module tb_top;
    import topt_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_BYTES  = 630;
    localparam int TAIL_CYCLES  = 10;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    topt_in_t  s_item = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    topt_out_t m_item;

    int fail_count;
    int outstanding;
    int checked_count;

    // idle mix, changed between phases
    int send_gap_pct = 16;
    int recv_stall_pct = 55;

    int cycle_count = 0;
    int bytes_sent = 0;
    int segments_sent = 0;

    // option area of the segment being built
    logic [7:0] seg_q[$];

    tcp_option_parser u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    topt_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_item        (s_item),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_item        (m_item),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .checked_count (checked_count)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // receiver stalls at random, rate follows the current phase
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // run guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, outstanding);
            $display("FAIL tcp_option_parser");
            $finish;
        end
    end

    // one byte transfer; valid stays high straight into the next byte unless a gap is drawn
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= '{opt_byte: b, last_byte: last};
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    task automatic send_segment();
        for (int i = 0; i < seg_q.size(); i++)
            send_byte(seg_q[i], i == seg_q.size() - 1);
        segments_sent++;
    endtask

    // mostly well-formed option lists with random content, the rest noise
    task automatic build_segment();
        int         pick;
        int         len;
        int         cut;
        logic [7:0] kind;
        logic [7:0] good_len;
        seg_q.delete();
        if ($urandom_range(99) < 25) begin
            // raw noise, sometimes past the walked window and the position ceiling
            len = ($urandom_range(19) == 0) ? $urandom_range(41, 70) : $urandom_range(1, 40);
            repeat (len) seg_q.push_back(8'($urandom));
        end else begin
            repeat ($urandom_range(0, 6)) begin
                pick = $urandom_range(99);
                if (pick < 10) begin
                    seg_q.push_back(KIND_NOP);
                end else if (pick < 30) begin
                    seg_q.push_back(KIND_MSS);
                    seg_q.push_back(LEN_MSS);
                    if ($urandom_range(7) == 0) begin
                        // all-zero or all-one mss
                        kind = $urandom_range(1) ? 8'hFF : 8'h00;
                        seg_q.push_back(kind);
                        seg_q.push_back(kind);
                    end else begin
                        seg_q.push_back(8'($urandom));
                        seg_q.push_back(8'($urandom));
                    end
                end else if (pick < 50) begin
                    seg_q.push_back(KIND_WSCALE);
                    seg_q.push_back(LEN_WSCALE);
                    // shift around the clamp point, sometimes a wild byte
                    seg_q.push_back(($urandom_range(3) == 0) ? 8'($urandom)
                                                             : 8'($urandom_range(0, 16)));
                end else if (pick < 70) begin
                    seg_q.push_back(KIND_TSTAMP);
                    seg_q.push_back(LEN_TSTAMP);
                    repeat (8) seg_q.push_back(8'($urandom));
                end else if (pick < 85) begin
                    // unknown kind, skipped by its length
                    kind = 8'($urandom_range(4, 255));
                    if (kind == KIND_TSTAMP) kind = kind + 8'd1;
                    len = $urandom_range(2, 8);
                    seg_q.push_back(kind);
                    seg_q.push_back(8'(len));
                    repeat (len - 2) seg_q.push_back(8'($urandom));
                end else begin
                    // known kind with the wrong length
                    case ($urandom_range(2))
                        0: begin
                            kind     = KIND_MSS;
                            good_len = LEN_MSS;
                        end
                        1: begin
                            kind     = KIND_WSCALE;
                            good_len = LEN_WSCALE;
                        end
                        default: begin
                            kind     = KIND_TSTAMP;
                            good_len = LEN_TSTAMP;
                        end
                    endcase
                    len = $urandom_range(2, 12);
                    if (len == good_len) len++;
                    seg_q.push_back(kind);
                    seg_q.push_back(8'(len));
                    repeat (len - 2) seg_q.push_back(8'($urandom));
                end
            end
            pick = $urandom_range(99);
            if (pick < 15) begin
                // end of list, then padding the walk must ignore
                seg_q.push_back(KIND_EOL);
                repeat ($urandom_range(0, 5))
                    seg_q.push_back($urandom_range(1) ? 8'($urandom) : KIND_EOL);
            end else if (pick < 22) begin
                // length byte of zero or one
                seg_q.push_back(8'($urandom_range(2, 255)));
                seg_q.push_back(8'($urandom_range(0, 1)));
            end else if (pick < 35 && seg_q.size() > 1) begin
                // area ends inside an option
                cut = seg_q.size() - 1;
                if (cut > 8) cut = 8;
                repeat ($urandom_range(1, cut)) void'(seg_q.pop_back());
            end else if (pick < 38) begin
                repeat ($urandom_range(30, 40)) seg_q.push_back(8'($urandom));
            end
        end
        if (seg_q.size() == 0) seg_q.push_back(8'($urandom));
    endtask

    initial begin
        int phase_start;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed segments
        // mss at all ones, scale byte far above the clamp
        seg_q = '{KIND_MSS, LEN_MSS, 8'hFF, 8'hFF, KIND_WSCALE, LEN_WSCALE, 8'hFF};
        send_segment();
        // timestamp value all ones, echo all zeros
        seg_q = '{KIND_TSTAMP, LEN_TSTAMP, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                  8'h00, 8'h00, 8'h00, 8'h00};
        send_segment();
        // no-op then end of list
        seg_q = '{KIND_NOP, KIND_EOL};
        send_segment();
        // length below the minimum
        seg_q = '{KIND_MSS, 8'h01};
        send_segment();
        // mss cut off by the end of the area
        seg_q = '{KIND_MSS, LEN_MSS, 8'h12};
        send_segment();
        // window scale with the wrong length
        seg_q = '{KIND_WSCALE, 8'h04, 8'h05, 8'h06};
        send_segment();

        // random segments under three idle mixes
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_gap_pct   = 16;
                    recv_stall_pct = 55;
                end
                1: begin
                    send_gap_pct   = 55;
                    recv_stall_pct = 16;
                end
                default: begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 0;
                end
            endcase
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                build_segment();
                send_segment();
            end
        end
        s_valid <= 1'b0;

        // drain, then let the pipeline settle
        do @(posedge aclk); while (outstanding != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("sent %0d segments in %0d option byte transfers, %0d results checked",
                 segments_sent, bytes_sent, checked_count);
        $display("covered directed corner segments and random walks under three idle mixes");
        if (fail_count == 0 && outstanding == 0) begin
            $display("PASS tcp_option_parser");
        end else begin
            $display("FAIL tcp_option_parser");
        end
        $finish;
    end

endmodule

>>> tcp_option_parser.f
+incdir+rtl
rtl/topt_pkg.sv
rtl/topt_walker.sv
rtl/tcp_option_parser.sv
test/topt_checker.sv
test/tb_top.sv
